// ===== rtl/apu_pkg.sv =====
// ----------------------------------------------------------------------------
// apu_pkg
// Types and constants shared by the Adam parameter update block.
// ----------------------------------------------------------------------------
package apu_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int IDX_W     = 5;

    localparam logic [1:0] CFG_LR     = 2'd0;
    localparam logic [1:0] CFG_BETA1  = 2'd1;
    localparam logic [1:0] CFG_BETA2  = 2'd2;
    localparam logic [1:0] CFG_EPS    = 2'd3;

    localparam logic [31:0] RST_LR    = 32'd34359738;
    localparam logic [31:0] RST_BETA1 = 32'd3865470566;
    localparam logic [31:0] RST_BETA2 = 32'd4290672329;
    localparam logic [15:0] RST_EPS   = 16'd43;

    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [33:0] STEP_CAP  = 34'h2_0000_0000;

    localparam logic [6:0] LEN_MAC    = 7'd33;
    localparam logic [6:0] LEN_WIDE   = 7'd64;
    localparam logic [6:0] LEN_SQRT   = 7'd32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POW1,
        S_POW2,
        S_MOM,
        S_GSQ,
        S_VAR,
        S_DIV1,
        S_DIV2,
        S_SQRT,
        S_DIV3,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]   param_index;
        logic signed [31:0] gradient;
        logic signed [31:0] weight_in;
        logic               first_of_step;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]   index_out;
        logic signed [31:0] weight_out;
        logic               clipped;
    } t_out_word;

endpackage

// ===== rtl/adam_parameter_update_top.sv =====
// ----------------------------------------------------------------------------
// adam_parameter_update_top
// Fixed point Adam update, one parameter slot per input word.
//
// Input words (slot index, gradient, weight, sweep start) arrive on a
// valid/ready channel; one output word (index, new weight, clip flag) is
// returned for each. Configuration is a plain write port, indexes 0 to 3:
// learning rate, beta1, beta2, epsilon.
// Each word runs through a sequencer over a shared bit-serial multiplier,
// a restoring divider (three divisions) and a two-bit-per-cycle square
// root. A word that starts a sweep takes two extra multiplies for the
// decay powers. One word is in flight at a time.
// The output register lets the next word be accepted while a result
// waits; a stalled receiver holds the block only when a second result
// is ready. Reset clears moments (valid bits), sets the decay powers to
// one, loads the default configuration and resets state and output valid.
// ----------------------------------------------------------------------------
module adam_parameter_update_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  apu_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output apu_pkg::t_out_word  o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_wdata
);
    import apu_pkg::*;

    t_state r_state, n_state;
    logic [6:0] r_cnt;
    logic [6:0] c_len;
    logic       c_last, c_in_ready, c_out_free;

    logic [31:0] r_lr, r_b1, r_b2;
    logic [15:0] r_eps;
    logic [32:0] r_p1, r_p2;

    logic [31:0] r_fm [NUM_SLOTS];
    logic [47:0] r_sm [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    logic [31:0] r_mrd;
    logic [47:0] r_vrd;
    logic        r_vld_rd;

    logic [IDX_W-1:0]   r_idx;
    logic signed [31:0] r_grad, r_win, r_m;
    logic               r_fos;
    logic [63:0]        r_mhat;

    logic signed [49:0] r_ma, r_mg;
    logic [63:0]        r_mb, r_ml;
    logic [32:0]        r_mc, r_mk;
    logic signed [52:0] r_mh;
    logic signed [52:0] c_sum;
    logic [116:0]       c_w;

    logic [41:0] r_drem, r_dden;
    logic [63:0] r_dlo, r_dq;
    logic        r_dsat;
    logic [41:0] c_dt;
    logic        c_dge;
    logic [63:0] c_dres;

    logic [63:0] r_sx;
    logic [33:0] r_srem, c_st, c_strial;
    logic [31:0] r_sroot;
    logic        c_sge;

    logic [31:0] c_mold, c_gmag, c_mmag;
    logic [47:0] c_vold;
    logic [32:0] c_c1, c_c2, c_corr1, c_corr2;
    logic [40:0] c_den3;
    logic [33:0] c_stepc;
    logic signed [34:0] c_wnew;
    logic        c_pos_ovf, c_neg_ovf;

    logic        r_out_valid;
    t_out_word   r_out;

    // control
    always_comb begin
        case (r_state)
            S_DIV1, S_DIV2, S_DIV3, S_STEP: c_len = LEN_WIDE;
            S_SQRT:                         c_len = LEN_SQRT;
            default:                        c_len = LEN_MAC;
        endcase
        c_last     = (r_cnt == c_len);
        c_out_free = !r_out_valid || i_out_ready;
        c_in_ready = (r_state == S_IDLE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = i_in.first_of_step ? S_POW1 : S_MOM;
            S_POW1: if (c_last) n_state = S_POW2;
            S_POW2: if (c_last) n_state = S_MOM;
            S_MOM:  if (c_last) n_state = S_GSQ;
            S_GSQ:  if (c_last) n_state = S_VAR;
            S_VAR:  if (c_last) n_state = S_DIV1;
            S_DIV1: if (c_last) n_state = S_DIV2;
            S_DIV2: if (c_last) n_state = S_SQRT;
            S_SQRT: if (c_last) n_state = S_DIV3;
            S_DIV3: if (c_last) n_state = S_STEP;
            S_STEP: if (c_last) n_state = S_DONE;
            S_DONE: if (c_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE || r_state == S_DONE || c_last) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    // datapath helpers
    assign c_mold  = r_vld_rd ? r_mrd : 32'd0;
    assign c_vold  = r_vld_rd ? r_vrd : 48'd0;
    assign c_gmag  = r_grad[31] ? 32'(-r_grad) : r_grad;
    assign c_mmag  = r_m[31] ? 32'(-r_m) : r_m;
    assign c_c1    = ONE_Q32 - {1'b0, r_b1};
    assign c_c2    = ONE_Q32 - {1'b0, r_b2};
    assign c_corr1 = r_p1[32] ? 33'd1 : (ONE_Q32 - r_p1);
    assign c_corr2 = r_p2[32] ? 33'd1 : (ONE_Q32 - r_p2);

    assign c_sum = r_mh
                 + (r_mb[0] ? {{3{r_ma[49]}}, r_ma} : 53'sd0)
                 + (r_mc[0] ? {{3{r_mg[49]}}, r_mg} : 53'sd0)
                 + $signed({52'd0, r_mk[0]});
    assign c_w   = {r_mh, r_ml};

    assign c_dt   = {r_drem[40:0], r_dlo[63]};
    assign c_dge  = (c_dt >= r_dden);
    assign c_dres = r_dsat ? {64{1'b1}} : r_dq;

    assign c_st     = {r_srem[31:0], r_sx[63:62]};
    assign c_strial = {r_sroot, 2'b01};
    assign c_sge    = (c_st >= c_strial);

    always_comb begin
        c_den3 = {1'b0, r_sroot, 8'd0} + {25'd0, r_eps};
        if (c_den3 == 41'd0) begin
            c_den3 = 41'd1;
        end
    end

    always_comb begin
        if ((|c_w[95:66]) || (c_w[65] && (|c_w[64:32]))) begin
            c_stepc = STEP_CAP;
        end else begin
            c_stepc = c_w[65:32];
        end
        if (r_m[31]) begin
            c_wnew = {{3{r_win[31]}}, r_win} + $signed({1'b0, c_stepc});
        end else begin
            c_wnew = {{3{r_win[31]}}, r_win} - $signed({1'b0, c_stepc});
        end
        c_pos_ovf = !c_wnew[34] && (c_wnew[33:31] != 3'b000);
        c_neg_ovf = c_wnew[34] && (c_wnew[33:31] != 3'b111);
    end

    // configuration and decay powers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= RST_LR;
            r_b1  <= RST_BETA1;
            r_b2  <= RST_BETA2;
            r_eps <= RST_EPS;
            r_p1  <= ONE_Q32;
            r_p2  <= ONE_Q32;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LR:    r_lr  <= i_cfg_wdata;
                    CFG_BETA1: r_b1  <= i_cfg_wdata;
                    CFG_BETA2: r_b2  <= i_cfg_wdata;
                    CFG_EPS:   r_eps <= i_cfg_wdata[15:0];
                    default:   r_lr  <= r_lr;
                endcase
            end
            if (r_state == S_POW2 && r_cnt == 7'd0) begin
                r_p1 <= c_w[95:63];
            end
            if (r_state == S_MOM && r_cnt == 7'd0 && r_fos) begin
                r_p2 <= c_w[95:63];
            end
        end
    end

    // moment store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (r_state == S_DIV1 && r_cnt == 7'd0) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_in_ready && i_in_valid) begin
            r_mrd    <= r_fm[i_in.param_index];
            r_vrd    <= r_sm[i_in.param_index];
            r_vld_rd <= r_valid[i_in.param_index];
            r_idx    <= i_in.param_index;
            r_grad   <= i_in.gradient;
            r_win    <= i_in.weight_in;
            r_fos    <= i_in.first_of_step;
        end
        if (r_state == S_DIV1 && r_cnt == 7'd0) begin
            r_fm[r_idx] <= r_m;
            r_sm[r_idx] <= c_w[110:63];
        end
    end

    // serial multiplier, divider and root
    always_ff @(posedge i_clk) begin
        if (r_cnt == 7'd0) begin
            case (r_state)
                S_POW1: begin
                    r_ma <= {17'd0, r_p1};
                    r_mb <= {32'd0, r_b1};
                    r_mg <= '0;
                    r_mc <= '0;
                    r_mk <= {2'b01, 31'd0};
                    r_mh <= '0;
                    r_ml <= '0;
                end
                S_POW2: begin
                    r_ma <= {17'd0, r_p2};
                    r_mb <= {32'd0, r_b2};
                    r_mg <= '0;
                    r_mc <= '0;
                    r_mk <= {2'b01, 31'd0};
                    r_mh <= '0;
                    r_ml <= '0;
                end
                S_MOM: begin
                    r_ma <= {{18{c_mold[31]}}, c_mold};
                    r_mb <= {32'd0, r_b1};
                    r_mg <= {{18{r_grad[31]}}, r_grad};
                    r_mc <= c_c1;
                    r_mk <= {2'b01, 31'd0};
                    r_mh <= '0;
                    r_ml <= '0;
                end
                S_GSQ: begin
                    r_m  <= c_w[94:63];
                    r_ma <= {18'd0, c_gmag};
                    r_mb <= {32'd0, c_gmag};
                    r_mg <= '0;
                    r_mc <= '0;
                    r_mk <= {17'd0, 16'h8000};
                    r_mh <= '0;
                    r_ml <= '0;
                end
                S_VAR: begin
                    r_ma <= {2'd0, c_vold};
                    r_mb <= {32'd0, r_b2};
                    r_mg <= {3'd0, c_w[93:47]};
                    r_mc <= c_c2;
                    r_mk <= {2'b01, 31'd0};
                    r_mh <= '0;
                    r_ml <= '0;
                end
                S_DIV1: begin
                    r_dden <= {9'd0, c_corr1};
                    r_dsat <= 1'b0;
                    r_drem <= '0;
                    r_dlo  <= {c_mmag, 32'd0};
                    r_dq   <= '0;
                end
                S_DIV2: begin
                    r_mhat <= c_dres;
                    r_dden <= {9'd0, c_corr2};
                    r_dsat <= ({10'd0, c_w[110:79]} >= {9'd0, c_corr2});
                    r_drem <= {10'd0, c_w[110:79]};
                    r_dlo  <= {c_w[78:63], 48'd0};
                    r_dq   <= '0;
                end
                S_SQRT: begin
                    r_sx    <= c_dres;
                    r_srem  <= '0;
                    r_sroot <= '0;
                end
                S_DIV3: begin
                    r_dden <= {1'b0, c_den3};
                    r_dsat <= ({10'd0, r_mhat[63:32]} >= {1'b0, c_den3});
                    r_drem <= {10'd0, r_mhat[63:32]};
                    r_dlo  <= {r_mhat[31:0], 32'd0};
                    r_dq   <= '0;
                end
                S_STEP: begin
                    r_ma <= {18'd0, r_lr};
                    r_mb <= c_dres;
                    r_mg <= '0;
                    r_mc <= '0;
                    r_mk <= '0;
                    r_mh <= '0;
                    r_ml <= '0;
                end
                default: r_mk <= r_mk;
            endcase
        end else begin
            case (r_state)
                S_POW1, S_POW2, S_MOM, S_GSQ, S_VAR, S_STEP: begin
                    r_mh <= c_sum >>> 1;
                    r_ml <= {c_sum[0], r_ml[63:1]};
                    r_mb <= {1'b0, r_mb[63:1]};
                    r_mc <= {1'b0, r_mc[32:1]};
                    r_mk <= {1'b0, r_mk[32:1]};
                end
                S_DIV1, S_DIV2, S_DIV3: begin
                    r_drem <= c_dge ? (c_dt - r_dden) : c_dt;
                    r_dlo  <= {r_dlo[62:0], 1'b0};
                    r_dq   <= {r_dq[62:0], c_dge};
                end
                S_SQRT: begin
                    r_srem  <= c_sge ? (c_st - c_strial) : c_st;
                    r_sx    <= {r_sx[61:0], 2'b00};
                    r_sroot <= {r_sroot[30:0], c_sge};
                end
                default: r_mk <= r_mk;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && c_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && c_out_free) begin
            r_out.index_out <= r_idx;
            r_out.clipped   <= c_pos_ovf || c_neg_ovf;
            if (c_pos_ovf) begin
                r_out.weight_out <= 32'sh7FFF_FFFF;
            end else if (c_neg_ovf) begin
                r_out.weight_out <= 32'sh8000_0000;
            end else begin
                r_out.weight_out <= c_wnew[31:0];
            end
        end
    end

    assign o_in_ready  = c_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
